### hdl/tile_pixel_fetch_and_palette_assert.svh
// Assertion macros shared by the tile pixel fetch RTL.
// Each macro expects clk and rst_n in scope.
`ifndef TILE_PIXEL_FETCH_AND_PALETTE_ASSERT_SVH
`define TILE_PIXEL_FETCH_AND_PALETTE_ASSERT_SVH

// Condition holds at every edge outside reset.
`define TPF_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TPF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/tpf_pkg.sv
// ----------------------------------------------------------------------------
// tpf_pkg
// Types and constants shared by the tile pixel fetch and palette block.
// ----------------------------------------------------------------------------
`default_nettype none

package tpf_pkg;

  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);

  // Command codes
  localparam logic [1:0] CMD_WRITE    = 2'd0;
  localparam logic [1:0] CMD_PIXEL    = 2'd1;
  localparam logic [1:0] CMD_BACKDROP = 2'd2;
  localparam logic [1:0] CMD_NONE     = 2'd3;

  // Register indexes (byte address = 8 * index)
  localparam int unsigned CFG_AW = 6;
  localparam logic [2:0] REG_FOUR_BPP  = 3'd0;
  localparam logic [2:0] REG_PACKED    = 3'd1;
  localparam logic [2:0] REG_GRAY      = 3'd2;
  localparam logic [2:0] REG_POOL      = 3'd3;
  localparam logic [2:0] REG_PAL_A     = 3'd4;
  localparam logic [2:0] REG_PAL_B     = 3'd5;
  localparam logic [2:0] REG_PAL_C     = 3'd6;
  localparam logic [2:0] REG_PAL_D     = 3'd7;

  localparam logic [MEM_AW-1:0] TILE_BASE_2BPP = 16'h2000;
  localparam logic [MEM_AW-1:0] TILE_BASE_4BPP = 16'h4000;
  localparam logic [MEM_AW-1:0] PALETTE_BASE   = 16'hFE00;

  // Command queue
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam logic [Q_AW:0] Q_FULL = (Q_AW + 1)'(Q_DEPTH);

  typedef struct packed {
    logic              four_bpp;
    logic              packed_layout;
    logic              gray;
    logic [31:0]       shade_pool;
    logic [3:0][47:0]  pal_shades;
  } cfg_t;

  // One queued operation; addr is the write address or the first tile byte
  typedef struct packed {
    logic [1:0]        kind;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        wdata;
    logic [1:0]        last_k;
    logic [2:0]        col;
    logic [3:0]        pal;
    logic [7:0]        bidx;
  } op_t;

endpackage

`default_nettype wire

### hdl/tpf_regs.sv
// ----------------------------------------------------------------------------
// tpf_regs
// APB configuration registers: tile depth, layout, gray mode and shade tables.
// ----------------------------------------------------------------------------
`default_nettype none

module tpf_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tpf_pkg::CFG_AW-1:0] paddr,
  input  wire logic [63:0]                pwdata,
  output logic      [63:0]                prdata,
  output logic                            pready,
  output tpf_pkg::cfg_t                   cfg
);

  tpf_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.four_bpp      <= 1'b0;
      cfg_r.packed_layout <= 1'b0;
      cfg_r.gray          <= 1'b1;
      cfg_r.shade_pool    <= '0;
      cfg_r.pal_shades    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        tpf_pkg::REG_FOUR_BPP: cfg_r.four_bpp      <= pwdata[0];
        tpf_pkg::REG_PACKED:   cfg_r.packed_layout <= pwdata[0];
        tpf_pkg::REG_GRAY:     cfg_r.gray          <= pwdata[0];
        tpf_pkg::REG_POOL:     cfg_r.shade_pool    <= pwdata[31:0];
        tpf_pkg::REG_PAL_A:    cfg_r.pal_shades[0] <= pwdata[47:0];
        tpf_pkg::REG_PAL_B:    cfg_r.pal_shades[1] <= pwdata[47:0];
        tpf_pkg::REG_PAL_C:    cfg_r.pal_shades[2] <= pwdata[47:0];
        tpf_pkg::REG_PAL_D:    cfg_r.pal_shades[3] <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      tpf_pkg::REG_FOUR_BPP: prdata = {63'b0, cfg_r.four_bpp};
      tpf_pkg::REG_PACKED:   prdata = {63'b0, cfg_r.packed_layout};
      tpf_pkg::REG_GRAY:     prdata = {63'b0, cfg_r.gray};
      tpf_pkg::REG_POOL:     prdata = {32'b0, cfg_r.shade_pool};
      tpf_pkg::REG_PAL_A:    prdata = {16'b0, cfg_r.pal_shades[0]};
      tpf_pkg::REG_PAL_B:    prdata = {16'b0, cfg_r.pal_shades[1]};
      tpf_pkg::REG_PAL_C:    prdata = {16'b0, cfg_r.pal_shades[2]};
      tpf_pkg::REG_PAL_D:    prdata = {16'b0, cfg_r.pal_shades[3]};
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/tpf_front.sv
// ----------------------------------------------------------------------------
// tpf_front
// Accepts commands, drops unknown codes and resolves tile byte addressing.
// ----------------------------------------------------------------------------
`default_nettype none

module tpf_front (
  input  wire logic                       start,
  input  wire logic                       q_full,
  input  wire logic [1:0]                 in_cmd,
  input  wire logic [tpf_pkg::MEM_AW-1:0] in_mem_address,
  input  wire logic [7:0]                 in_write_byte,
  input  wire logic [9:0]                 in_tile_number,
  input  wire logic [2:0]                 in_pixel_col,
  input  wire logic [2:0]                 in_pixel_row,
  input  wire logic [3:0]                 in_palette_number,
  input  wire logic [7:0]                 in_backdrop_index,
  input  wire tpf_pkg::cfg_t              cfg,
  output logic                            busy,
  output logic                            q_push,
  output tpf_pkg::op_t                    q_din
);

  logic [tpf_pkg::MEM_AW-1:0] row_base_4;
  logic [tpf_pkg::MEM_AW-1:0] row_base_2;
  logic [tpf_pkg::MEM_AW-1:0] tile_addr;

  assign busy = q_full;

  // Row start of the tile, wrapping at 16 bits
  assign row_base_4 = tpf_pkg::TILE_BASE_4BPP + {1'b0, in_tile_number, 5'b0}
                    + {11'b0, in_pixel_row, 2'b0};
  assign row_base_2 = tpf_pkg::TILE_BASE_2BPP + {3'b0, in_tile_number[8:0], 4'b0}
                    + {12'b0, in_pixel_row, 1'b0};

  always_comb begin
    if (cfg.four_bpp) begin
      tile_addr = cfg.packed_layout ? row_base_4 + {14'b0, in_pixel_col[2:1]} : row_base_4;
    end else begin
      tile_addr = cfg.packed_layout ? row_base_2 + {15'b0, in_pixel_col[2]} : row_base_2;
    end
  end

  always_comb begin
    q_din.kind   = in_cmd;
    q_din.addr   = tile_addr;
    q_din.wdata  = in_write_byte;
    q_din.col    = in_pixel_col;
    q_din.pal    = in_palette_number;
    q_din.bidx   = in_backdrop_index;
    q_din.last_k = cfg.packed_layout ? 2'd0 : (cfg.four_bpp ? 2'd3 : 2'd1);
    q_push       = 1'b0;
    unique case (in_cmd) inside
      tpf_pkg::CMD_WRITE: begin
        q_din.addr = in_mem_address;
        q_push     = start && !q_full;
      end
      tpf_pkg::CMD_PIXEL,
      tpf_pkg::CMD_BACKDROP: begin
        q_push = start && !q_full;
      end
      default: q_push = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/tpf_fifo.sv
// ----------------------------------------------------------------------------
// tpf_fifo
// Small operation queue between the command front end and the fetch engine.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tile_pixel_fetch_and_palette_assert.svh"

module tpf_fifo (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire tpf_pkg::op_t din,
  input  wire logic   pop,
  output tpf_pkg::op_t dout,
  output logic        empty,
  output logic        full
);

  tpf_pkg::op_t               entry_r [tpf_pkg::Q_DEPTH];
  logic [tpf_pkg::Q_AW-1:0]   wr_ptr_r;
  logic [tpf_pkg::Q_AW-1:0]   rd_ptr_r;
  logic [tpf_pkg::Q_AW:0]     count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == tpf_pkg::Q_FULL);
  assign dout  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `TPF_ASSERT_HOLDS(a_q_no_overflow, !(push && full), "queue push while full")
  `TPF_ASSERT_HOLDS(a_q_no_underflow, !(pop && empty), "queue pop while empty")

endmodule

`default_nettype wire

### hdl/tpf_back.sv
// ----------------------------------------------------------------------------
// tpf_back
// Fetch engine: owns the byte memory, reads tile bytes, extracts the color
// index and resolves the output color from the shade tables or palette words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tile_pixel_fetch_and_palette_assert.svh"

module tpf_back (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire tpf_pkg::cfg_t cfg,
  input  wire logic   q_empty,
  input  wire tpf_pkg::op_t q_head,
  output logic        q_pop,
  output logic        out_valid,
  output logic [3:0]  out_color_index,
  output logic        out_is_opaque,
  output logic [11:0] out_rgb_color
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TILE  = 3'd1;
  localparam logic [2:0] S_COLOR = 3'd2;
  localparam logic [2:0] S_PLO   = 3'd3;
  localparam logic [2:0] S_PHI   = 3'd4;

  logic [7:0] mem [tpf_pkg::MEM_BYTES];

  logic [2:0]                 state_r, state_nxt;
  tpf_pkg::op_t               op_r, op_nxt;
  logic [2:0]                 k_issue_r, k_issue_nxt;
  logic [1:0]                 k_data_r, k_data_nxt;
  logic [3:0]                 idx_r, idx_nxt;
  logic [tpf_pkg::MEM_AW-1:0] pa_r, pa_nxt;
  logic [7:0]                 lo_r, lo_nxt;
  logic [7:0]                 rdata_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [3:0]                 out_ci_r, out_ci_nxt;
  logic                       out_op_r, out_op_nxt;
  logic [11:0]                out_rgb_r, out_rgb_nxt;

  logic                       rd_en;
  logic [tpf_pkg::MEM_AW-1:0] rd_addr;
  logic                       mem_we;

  logic                       is_pix;
  logic [3:0]                 idx_acc;
  logic [tpf_pkg::MEM_AW-1:0] pal_addr;
  logic [47:0]                shade_set;
  logic [11:0]                pal_entry;
  logic [2:0]                 pool_idx;
  logic [3:0]                 luma;
  logic                       pix_opaque;

  assign is_pix = (op_r.kind == tpf_pkg::CMD_PIXEL);

  // One tile byte per cycle: planar gathers one bit per byte, packed slices a field
  always_comb begin
    if (cfg.packed_layout) begin
      idx_acc = cfg.four_bpp ? rdata_r[{~op_r.col[0], 2'b00} +: 4]
                             : {2'b0, rdata_r[{~op_r.col[1:0], 1'b0} +: 2]};
    end else begin
      idx_acc = idx_r | (4'(rdata_r[~op_r.col]) << k_data_r);
    end
  end

  assign pal_addr = is_pix
    ? tpf_pkg::PALETTE_BASE + {7'b0, op_r.pal, 5'b0} + {11'b0, idx_r, 1'b0}
    : tpf_pkg::PALETTE_BASE + {7'b0, op_r.bidx, 1'b0};

  assign shade_set = cfg.pal_shades[op_r.pal[3:2]];
  assign pal_entry = shade_set[6'(op_r.pal[1:0]) * 6'd12 +: 12];
  assign pool_idx  = is_pix ? pal_entry[4'(idx_r[1:0]) * 4'd3 +: 3] : op_r.bidx[2:0];
  assign luma      = ~cfg.shade_pool[{pool_idx, 2'b00} +: 4];
  assign pix_opaque = (idx_r != 4'd0) || (!cfg.four_bpp && !op_r.pal[2]);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    k_issue_nxt   = k_issue_r;
    k_data_nxt    = k_data_r;
    idx_nxt       = idx_r;
    pa_nxt        = pa_r;
    lo_nxt        = lo_r;
    out_valid_nxt = 1'b0;
    out_ci_nxt    = out_ci_r;
    out_op_nxt    = out_op_r;
    out_rgb_nxt   = out_rgb_r;
    rd_en         = 1'b0;
    rd_addr       = op_r.addr + tpf_pkg::MEM_AW'(k_issue_r);
    mem_we        = 1'b0;
    q_pop         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop  = 1'b1;
          op_nxt = q_head;
          unique case (q_head.kind)
            tpf_pkg::CMD_WRITE: mem_we = 1'b1;
            tpf_pkg::CMD_PIXEL: begin
              rd_en       = 1'b1;
              rd_addr     = q_head.addr;
              k_issue_nxt = 3'd1;
              k_data_nxt  = 2'd0;
              idx_nxt     = 4'd0;
              state_nxt   = S_TILE;
            end
            tpf_pkg::CMD_BACKDROP: state_nxt = S_COLOR;
            default: ;
          endcase
        end
      end
      S_TILE: begin
        if (k_issue_r <= {1'b0, op_r.last_k}) begin
          rd_en       = 1'b1;
          k_issue_nxt = k_issue_r + 3'd1;
        end
        idx_nxt    = idx_acc;
        k_data_nxt = k_data_r + 2'd1;
        if (k_data_r == op_r.last_k) begin
          state_nxt = S_COLOR;
        end
      end
      S_COLOR: begin
        out_ci_nxt = is_pix ? idx_r : 4'd0;
        out_op_nxt = is_pix && pix_opaque;
        if (cfg.gray) begin
          out_valid_nxt = 1'b1;
          out_rgb_nxt   = {luma, luma, luma};
          state_nxt     = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = pal_addr;
          pa_nxt    = pal_addr + 1'b1;
          state_nxt = S_PLO;
        end
      end
      S_PLO: begin
        lo_nxt    = rdata_r;
        rd_en     = 1'b1;
        rd_addr   = pa_r;
        state_nxt = S_PHI;
      end
      S_PHI: begin
        out_valid_nxt = 1'b1;
        out_rgb_nxt   = {rdata_r[3:0], lo_r};
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_head.addr] <= q_head.wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    k_issue_r <= k_issue_nxt;
    k_data_r  <= k_data_nxt;
    idx_r     <= idx_nxt;
    pa_r      <= pa_nxt;
    lo_r      <= lo_nxt;
    out_ci_r  <= out_ci_nxt;
    out_op_r  <= out_op_nxt;
    out_rgb_r <= out_rgb_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_ci_r;
  assign out_is_opaque   = out_op_r;
  assign out_rgb_color   = out_rgb_r;

  `TPF_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r, "result strobe lasted two cycles")
  `TPF_ASSERT_IMPLIES(a_tile_is_pixel, state_r == S_TILE, is_pix, "tile fetch for non-pixel op")
  `TPF_ASSERT_NEXT(a_phi_emits, state_r == S_PHI, out_valid_r, "palette word read gave no result")

endmodule

`default_nettype wire

### hdl/tile_pixel_fetch_and_palette.sv
// ----------------------------------------------------------------------------
// tile_pixel_fetch_and_palette
// Tile pixel fetch and palette color lookup over a 64 KiB byte memory.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start/in_* and are taken at an edge where start is high
//   and busy is low. A memory write gives no result.
//   Pixel and backdrop commands give one result, shown for a single cycle on
//   out_valid/out_*; the receiver must take it then, nothing holds it back.
//   A two-entry queue sits between command intake and the fetch engine, so
//   busy only rises when two commands are already waiting.
//   Pixel commands read n tile bytes (1 packed, 2 planar 2 bpp, 4 planar
//   4 bpp), then take a shade from the pool in grayscale mode or else read a
//   two-byte color word from memory; backdrop commands read no tile bytes.
//   Engine occupancy per command is set by the single byte-wide memory port
//   that serves every tile and palette byte; one command is handled at a time.
//   Configuration is an APB port, 64-bit registers at byte address 8*index;
//   write it only while no command is in flight.
//   Reset (rst_n low, synchronous) empties the queue, idles the engine and
//   loads register defaults; memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_pixel_fetch_and_palette (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 in_cmd,
  input  wire logic [15:0]                in_mem_address,
  input  wire logic [7:0]                 in_write_byte,
  input  wire logic [9:0]                 in_tile_number,
  input  wire logic [2:0]                 in_pixel_col,
  input  wire logic [2:0]                 in_pixel_row,
  input  wire logic [3:0]                 in_palette_number,
  input  wire logic [7:0]                 in_backdrop_index,
  output logic                            out_valid,
  output logic [3:0]                      out_color_index,
  output logic                            out_is_opaque,
  output logic [11:0]                     out_rgb_color,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tpf_pkg::CFG_AW-1:0] paddr,
  input  wire logic [63:0]                pwdata,
  output logic      [63:0]                prdata,
  output logic                            pready
);

  tpf_pkg::cfg_t cfg;
  tpf_pkg::op_t  q_din;
  tpf_pkg::op_t  q_head;
  logic          q_push;
  logic          q_pop;
  logic          q_empty;
  logic          q_full;

  tpf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpf_front u_front (
    .start             (start),
    .q_full            (q_full),
    .in_cmd            (in_cmd),
    .in_mem_address    (in_mem_address),
    .in_write_byte     (in_write_byte),
    .in_tile_number    (in_tile_number),
    .in_pixel_col      (in_pixel_col),
    .in_pixel_row      (in_pixel_row),
    .in_palette_number (in_palette_number),
    .in_backdrop_index (in_backdrop_index),
    .cfg               (cfg),
    .busy              (busy),
    .q_push            (q_push),
    .q_din             (q_din)
  );

  tpf_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty),
    .full  (q_full)
  );

  tpf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_color_index (out_color_index),
    .out_is_opaque   (out_is_opaque),
    .out_rgb_color   (out_rgb_color)
  );

endmodule

`default_nettype wire

### test/tb_tile_pixel_fetch_and_palette.sv
// ----------------------------------------------------------------------------
// tb_tile_pixel_fetch_and_palette
// Self-checking bench for the tile pixel fetch and palette block: a directed
// table followed by random phases under changing register settings. Every
// pixel and backdrop result is checked, some directed rows against hand-computed
// values, the rest against a local predictor of byte memory and register file.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tile_pixel_fetch_and_palette;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_PHASES      = 6;
  localparam int DRAIN_CYCLES    = 32;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] mem_address;
    logic [7:0]  write_byte;
    logic [9:0]  tile_number;
    logic [2:0]  pixel_col;
    logic [2:0]  pixel_row;
    logic [3:0]  palette_number;
    logic [7:0]  backdrop_index;
  } tpf_item_t;

  typedef struct packed {
    logic [3:0]  color_index;
    logic        is_opaque;
    logic [11:0] rgb_color;
  } pixel_color_t;

  typedef struct {
    bit           is_reg;
    logic [2:0]   reg_sel;
    logic [63:0]  reg_val;
    tpf_item_t    item;
    bit           has_result;
    pixel_color_t result;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_cmd;
  logic [15:0]       in_mem_address;
  logic [7:0]        in_write_byte;
  logic [9:0]        in_tile_number;
  logic [2:0]        in_pixel_col;
  logic [2:0]        in_pixel_row;
  logic [3:0]        in_palette_number;
  logic [7:0]        in_backdrop_index;
  logic              out_valid;
  logic [3:0]        out_color_index;
  logic              out_is_opaque;
  logic [11:0]       out_rgb_color;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [tpf_pkg::CFG_AW-1:0] paddr;
  logic [63:0]       pwdata;
  logic [63:0]       prdata;
  logic              pready;

  // Mirror of the block's memory and registers
  logic [7:0]     vram [0:65535];
  bit             vram_written [0:65535];
  tpf_pkg::cfg_t  shadow_cfg;

  pixel_color_t pending_colors[$];
  stim_row_t    dir_rows[$];

  int idle_pct;
  int mismatch_count;
  int items_sent;
  int pixel_count, backdrop_count, write_count, nop_count, reg_write_count;

  tile_pixel_fetch_and_palette dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic logic [15:0] tile_row_base(tpf_item_t it);
    if (shadow_cfg.four_bpp)
      return tpf_pkg::TILE_BASE_4BPP + {1'b0, it.tile_number, 5'd0}
             + {11'd0, it.pixel_row, 2'd0};
    return tpf_pkg::TILE_BASE_2BPP + {3'd0, it.tile_number[8:0], 4'd0}
           + {12'd0, it.pixel_row, 1'b0};
  endfunction

  function automatic logic [11:0] gray_rgb(logic [2:0] slot);
    logic [3:0] luma;
    luma = 4'hF - shadow_cfg.shade_pool[{slot, 2'b00} +: 4];
    return {luma, luma, luma};
  endfunction

  // Little-endian word, upper nibble dropped
  function automatic logic [11:0] mem_word(logic [15:0] addr);
    logic [15:0] hi;
    hi = addr + 16'd1;
    return {vram[hi][3:0], vram[addr]};
  endfunction

  function automatic pixel_color_t compute_pixel_color(tpf_item_t it);
    pixel_color_t r;
    logic [15:0]  base;
    logic [7:0]   d;
    logic [47:0]  shade_set;
    logic [2:0]   slot;
    int           off;
    r = '0;
    if (it.cmd == tpf_pkg::CMD_BACKDROP) begin
      r.rgb_color = shadow_cfg.gray ? gray_rgb(it.backdrop_index[2:0])
                  : mem_word(tpf_pkg::PALETTE_BASE + {7'd0, it.backdrop_index, 1'b0});
      return r;
    end
    base = tile_row_base(it);
    if (shadow_cfg.packed_layout) begin
      // leftmost pixel sits in the high bits of the byte
      if (shadow_cfg.four_bpp) begin
        d = vram[base + 16'(it.pixel_col[2:1])];
        d = d << {it.pixel_col[0], 2'b00};
        r.color_index = d[7:4];
      end else begin
        d = vram[base + 16'(it.pixel_col[2])];
        d = d << {it.pixel_col[1:0], 1'b0};
        r.color_index = {2'b00, d[7:6]};
      end
    end else begin
      for (int k = 0; k < (shadow_cfg.four_bpp ? 4 : 2); k++)
        r.color_index[k] = vram[base + 16'(k)][3'd7 - it.pixel_col];
    end
    r.is_opaque = (r.color_index != 4'd0) ||
                  (!shadow_cfg.four_bpp && !it.palette_number[2]);
    if (shadow_cfg.gray) begin
      shade_set = shadow_cfg.pal_shades[it.palette_number[3:2]];
      off = 12 * int'(it.palette_number[1:0]) + 3 * int'(r.color_index[1:0]);
      slot = shade_set[off +: 3];
      r.rgb_color = gray_rgb(slot);
    end else begin
      r.rgb_color = mem_word(tpf_pkg::PALETTE_BASE
                             + {7'd0, it.palette_number, r.color_index, 1'b0});
    end
    return r;
  endfunction

  // ---------------- stimulus ----------------

  function automatic tpf_item_t rand_item(logic [1:0] cmd);
    tpf_item_t it;
    it.cmd            = cmd;
    it.mem_address    = 16'($urandom);
    it.write_byte     = 8'($urandom);
    it.tile_number    = 10'($urandom);
    it.pixel_col      = 3'($urandom);
    it.pixel_row      = 3'($urandom);
    it.palette_number = 4'($urandom);
    it.backdrop_index = 8'($urandom);
    return it;
  endfunction

  task automatic send_item(tpf_item_t it, bit has_result, pixel_color_t result);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start             <= 1'b1;
    in_cmd            <= it.cmd;
    in_mem_address    <= it.mem_address;
    in_write_byte     <= it.write_byte;
    in_tile_number    <= it.tile_number;
    in_pixel_col      <= it.pixel_col;
    in_pixel_row      <= it.pixel_row;
    in_palette_number <= it.palette_number;
    in_backdrop_index <= it.backdrop_index;
    do @(posedge clk); while (busy);
    items_sent++;
    case (it.cmd) inside
      tpf_pkg::CMD_WRITE: begin
        vram[it.mem_address]         = it.write_byte;
        vram_written[it.mem_address] = 1'b1;
        write_count++;
      end
      tpf_pkg::CMD_PIXEL, tpf_pkg::CMD_BACKDROP: begin
        pending_colors.push_back(has_result ? result : compute_pixel_color(it));
        if (it.cmd == tpf_pkg::CMD_PIXEL) pixel_count++;
        else backdrop_count++;
      end
      default: nop_count++;
    endcase
  endtask

  // Writes random data to any byte of a range that has never been written
  task automatic load_bytes(logic [15:0] first, int n);
    tpf_item_t   w;
    logic [15:0] a;
    for (int i = 0; i < n; i++) begin
      a = first + 16'(i);
      if (!vram_written[a]) begin
        w = rand_item(tpf_pkg::CMD_WRITE);
        w.mem_address = a;
        send_item(w, 1'b0, '0);
      end
    end
  endtask

  // Make sure every byte the transaction may read holds written data
  task automatic load_sources(tpf_item_t it);
    if (it.cmd == tpf_pkg::CMD_PIXEL) begin
      load_bytes(tile_row_base(it), shadow_cfg.four_bpp ? 4 : 2);
      if (!shadow_cfg.gray)
        load_bytes(tpf_pkg::PALETTE_BASE + {7'd0, it.palette_number, 5'd0}, 32);
    end else if (it.cmd == tpf_pkg::CMD_BACKDROP && !shadow_cfg.gray) begin
      load_bytes(tpf_pkg::PALETTE_BASE + {7'd0, it.backdrop_index, 1'b0}, 2);
    end
  endtask

  // Writes can still sit in the queue after the last result, hence the tail
  task automatic settle();
    int guard;
    start <= 1'b0;
    guard = 0;
    while (pending_colors.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] sel, logic [63:0] val);
    settle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {sel, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      tpf_pkg::REG_FOUR_BPP: shadow_cfg.four_bpp      = val[0];
      tpf_pkg::REG_PACKED:   shadow_cfg.packed_layout = val[0];
      tpf_pkg::REG_GRAY:     shadow_cfg.gray          = val[0];
      tpf_pkg::REG_POOL:     shadow_cfg.shade_pool    = val[31:0];
      default:      shadow_cfg.pal_shades[sel - tpf_pkg::REG_PAL_A] = val[47:0];
    endcase
    reg_write_count++;
  endtask

  // ---------------- directed table builders ----------------

  function automatic void push_item(tpf_item_t it);
    stim_row_t r;
    r.is_reg     = 1'b0;
    r.reg_sel    = '0;
    r.reg_val    = '0;
    r.item       = it;
    r.has_result = 1'b0;
    r.result     = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_write(logic [15:0] addr, logic [7:0] data);
    tpf_item_t it;
    it = rand_item(tpf_pkg::CMD_WRITE);
    it.mem_address = addr;
    it.write_byte  = data;
    push_item(it);
  endfunction

  function automatic void row_pixel(logic [9:0] tile, logic [2:0] col, logic [2:0] row,
                                    logic [3:0] pal);
    tpf_item_t it;
    it = rand_item(tpf_pkg::CMD_PIXEL);
    it.tile_number    = tile;
    it.pixel_col      = col;
    it.pixel_row      = row;
    it.palette_number = pal;
    push_item(it);
  endfunction

  function automatic void row_backdrop(logic [7:0] idx);
    tpf_item_t it;
    it = rand_item(tpf_pkg::CMD_BACKDROP);
    it.backdrop_index = idx;
    push_item(it);
  endfunction

  function automatic void row_reg(logic [2:0] sel, logic [63:0] val);
    stim_row_t r;
    r.is_reg     = 1'b1;
    r.reg_sel    = sel;
    r.reg_val    = val;
    r.item       = '0;
    r.has_result = 1'b0;
    r.result     = '0;
    dir_rows.push_back(r);
  endfunction

  // Attach a hand-computed result to the last row
  function automatic void with_result(logic [3:0] idx, logic opaque, logic [11:0] rgb);
    stim_row_t r;
    r = dir_rows.pop_back();
    r.has_result = 1'b1;
    r.result     = {idx, opaque, rgb};
    dir_rows.push_back(r);
  endfunction

  // ---------------- result check ----------------

  always @(posedge clk) begin : result_check
    pixel_color_t want;
    if (rst_n && out_valid) begin
      if (pending_colors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: unexpected result idx=%0h opq=%0b rgb=%03h",
                   out_color_index, out_is_opaque, out_rgb_color);
      end else begin
        want = pending_colors.pop_front();
        if (out_color_index !== want.color_index || out_is_opaque !== want.is_opaque ||
            out_rgb_color !== want.rgb_color) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: got idx=%0h opq=%0b rgb=%03h, expected idx=%0h opq=%0b rgb=%03h",
                     out_color_index, out_is_opaque, out_rgb_color,
                     want.color_index, want.is_opaque, want.rgb_color);
        end
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    tpf_item_t  it;
    int         pick;
    int         phase_end;
    logic [2:0] phb;

    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_cmd            <= tpf_pkg::CMD_NONE;
    in_mem_address    <= '0;
    in_write_byte     <= '0;
    in_tile_number    <= '0;
    in_pixel_col      <= '0;
    in_pixel_row      <= '0;
    in_palette_number <= '0;
    in_backdrop_index <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;

    shadow_cfg.four_bpp      = 1'b0;
    shadow_cfg.packed_layout = 1'b0;
    shadow_cfg.gray          = 1'b1;
    shadow_cfg.shade_pool    = '0;
    shadow_cfg.pal_shades    = '0;
    idle_pct = 6;
    items_sent = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: empty shade pool, so every gray lookup is white
    row_backdrop(8'hFF);                     with_result(4'd0, 1'b0, 12'hFFF);
    row_backdrop(8'h00);                     with_result(4'd0, 1'b0, 12'hFFF);
    row_write(16'h2000, 8'hFF);
    row_write(16'h2001, 8'h00);
    row_pixel(10'd0, 3'd0, 3'd0, 4'd0);      with_result(4'd1, 1'b1, 12'hFFF);
    // bit 9 of the tile number is dropped in 2 bpp
    row_pixel(10'h200, 3'd7, 3'd0, 4'hF);    with_result(4'd1, 1'b1, 12'hFFF);
    row_write(16'h2000, 8'h00);
    // index 0: transparent only when palette bit 2 is set
    row_pixel(10'd0, 3'd3, 3'd0, 4'd4);      with_result(4'd0, 1'b0, 12'hFFF);
    row_pixel(10'd0, 3'd3, 3'd0, 4'd3);      with_result(4'd0, 1'b1, 12'hFFF);
    push_item(rand_item(tpf_pkg::CMD_NONE));
    // upper bits of a register write are ignored
    row_reg(tpf_pkg::REG_POOL, '1);
    row_backdrop(8'h05);                     with_result(4'd0, 1'b0, 12'h000);
    row_reg(tpf_pkg::REG_PAL_A, '1);
    row_reg(tpf_pkg::REG_PAL_D, '1);
    row_pixel(10'h3FF, 3'd7, 3'd7, 4'hF);
    row_reg(tpf_pkg::REG_FOUR_BPP, 64'd1);
    row_pixel(10'h3FF, 3'd0, 3'd7, 4'hF);
    row_reg(tpf_pkg::REG_PACKED, 64'd1);
    row_pixel(10'h3FF, 3'd7, 3'd7, 4'h0);
    row_pixel(10'd0, 3'd0, 3'd0, 4'h8);
    row_reg(tpf_pkg::REG_GRAY, 64'd0);
    row_backdrop(8'hFF);
    row_pixel(10'h3FF, 3'd7, 3'd7, 4'hF);
    row_reg(tpf_pkg::REG_FOUR_BPP, 64'd0);
    row_pixel(10'h3FF, 3'd5, 3'd7, 4'h7);
    row_backdrop(8'h00);
    row_write(16'hFFFF, 8'hA5);
    row_write(16'h0000, 8'h5A);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
      end else begin
        load_sources(dir_rows[i].item);
        send_item(dir_rows[i].item, dir_rows[i].has_result, dir_rows[i].result);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      phb = 3'(ph);
      idle_pct = (ph < 2) ? 6 : (ph < 4) ? 69 : 0;
      write_reg(tpf_pkg::REG_FOUR_BPP, {32'($urandom), 31'($urandom), phb[0]});
      write_reg(tpf_pkg::REG_PACKED, {32'($urandom), 31'($urandom), phb[1]});
      write_reg(tpf_pkg::REG_GRAY, {32'($urandom), 31'($urandom), 1'((ph % 3) != 1)});
      write_reg(tpf_pkg::REG_POOL,
                (ph == 0) ? 64'd0 : (ph == 5) ? '1 : {$urandom, $urandom});
      for (int p = 0; p < 4; p++)
        write_reg(tpf_pkg::REG_PAL_A + 3'(p),
                  (ph == 0) ? 64'd0 : (ph == 5) ? '1 : {$urandom, $urandom});

      // source loads count toward the phase budget
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          it = rand_item(tpf_pkg::CMD_WRITE);
          // three quarters of the writes rework tile or palette data already in use
          case ($urandom_range(3))
            0: it.mem_address = {3'b001, it.mem_address[12:0]};
            1: it.mem_address = {2'b01, it.mem_address[13:0]};
            2: it.mem_address = {7'h7F, it.mem_address[8:0]};
            default: ;
          endcase
        end else if (pick < 20) begin
          it = rand_item(tpf_pkg::CMD_NONE);
        end else if (pick < 80) begin
          it = rand_item(tpf_pkg::CMD_PIXEL);
          if ($urandom_range(99) < 60)
            it.tile_number = {1'($urandom_range(1)), 6'd0, 3'($urandom_range(7))};
        end else begin
          it = rand_item(tpf_pkg::CMD_BACKDROP);
        end
        load_sources(it);
        send_item(it, 1'b0, '0);
      end
    end

    settle();
    $display("run covered %0d pixel, %0d backdrop, %0d memory write and %0d no-op transactions",
             pixel_count, backdrop_count, write_count, nop_count);
    $display("%0d register writes across %0d random phases, %0d mismatches, %0d results missing",
             reg_write_count, NUM_PHASES, mismatch_count, pending_colors.size());
    if (mismatch_count == 0 && pending_colors.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
